// ===== hdl/modular_exponentiation_defines.svh =====
// assertion macros used by the modular exponentiation checker
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// antecedent holds now, consequent holds in the next cycle
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// antecedent and consequent in the same cycle
`define MEXP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mexp_pkg.sv =====
// types and constants of the modular exponentiation block
package mexp_pkg;

  localparam int unsigned DataW        = 64;
  localparam int unsigned DefaultWidth = 64;
  localparam int unsigned CfgIdxW      = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULUS  = 2'd0,
    CFG_EXPONENT = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REDUCE = 4'b0010,
    S_EXP    = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

endpackage

// ===== hdl/mexp_modmul.sv =====
// bit-serial interleaved modular multiplier, a doubling phase and an add phase per multiplier bit
module mexp_modmul import mexp_pkg::*; #(
  parameter int unsigned WIDTH = DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH:0]   mod_i,
  output logic             done_o,
  output logic [WIDTH-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(WIDTH);

  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             phase_q, phase_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [WIDTH-1:0] addend;
  logic [WIDTH:0]   sum;
  logic [WIDTH+1:0] diff;

  // phase 0 doubles the accumulator, phase 1 adds a when the top bit of b is set
  assign addend = phase_q ? (b_q[WIDTH-1] ? a_q : '0) : acc_q;
  assign sum    = {1'b0, acc_q} + {1'b0, addend};
  assign diff   = {1'b0, sum} - {1'b0, mod_i};

  always_comb begin
    acc_d   = acc_q;
    a_d     = a_q;
    b_d     = b_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      acc_d   = '0;
      a_d     = a_i;
      b_d     = b_i;
      cnt_d   = '0;
      phase_d = 1'b0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      acc_d   = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];
      phase_d = ~phase_q;
      if (phase_q) begin
        b_d   = {b_q[WIDTH-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(WIDTH - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hdl/modular_exponentiation.sv =====
// modular exponentiation top level: right-to-left square-and-multiply sequencer
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[63:0] base_value
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata[63:0] power_result
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// one item runs the base reduction, then one square-and-multiply round per exponent bit up to
// the top set bit of the exponent; the bit-serial multipliers set how long an item takes
// the base reduction runs on the multiply unit, then square and multiply run in parallel
// reset clears the control state and sets modulus and exponent to one
// a finished result waits in the output register while the next request is taken
module modular_exponentiation import mexp_pkg::*; #(
  parameter int unsigned WIDTH = DefaultWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DataW-1:0]   s_axis_tdata,   // base_value
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DataW-1:0]   m_axis_tdata,   // power_result
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  state_e           state_q, state_d;
  logic [WIDTH-1:0] mod_q, exp_q;
  logic [WIDTH-1:0] e_q, e_d;
  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic             launch_q, launch_d;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] out_q, out_d;

  logic [WIDTH:0]   mod_ext;
  logic             in_take;
  logic             mul_start, sqr_start;
  logic [WIDTH-1:0] mul_a, mul_b;
  logic             mul_done, sqr_done;
  logic [WIDTH-1:0] mul_prod, sqr_prod;
  logic [WIDTH-1:0] e_next;

  // a zero modulus acts as 2^WIDTH
  assign mod_ext = {(mod_q == '0), mod_q};

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // in idle the multiply unit reduces the incoming base as 1 * base mod n
  assign mul_a     = (state_q == S_IDLE) ? WIDTH'(1) : r_q;
  assign mul_b     = (state_q == S_IDLE) ? s_axis_tdata[WIDTH-1:0] : b_q;
  assign mul_start = in_take | (launch_q & e_q[0]);
  assign sqr_start = launch_q;
  assign e_next    = e_q >> 1;

  mexp_modmul #(.WIDTH(WIDTH)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .mod_i   (mod_ext),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  mexp_modmul #(.WIDTH(WIDTH)) u_sqr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqr_start),
    .a_i     (b_q),
    .b_i     (b_q),
    .mod_i   (mod_ext),
    .done_o  (sqr_done),
    .prod_o  (sqr_prod)
  );

  always_comb begin
    state_d     = state_q;
    e_d         = e_q;
    r_d         = r_q;
    b_d         = b_q;
    launch_d    = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          e_d     = exp_q;
          r_d     = WIDTH'(1);
          state_d = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (mul_done) begin
          b_d = mul_prod;
          if (e_q == '0) begin
            state_d = S_DONE;
          end else begin
            launch_d = 1'b1;
            state_d  = S_EXP;
          end
        end
      end
      S_EXP: begin
        if (sqr_done) begin
          b_d = sqr_prod;
          if (e_q[0]) begin
            r_d = mul_prod;
          end
          e_d = e_next;
          if (e_next == '0) begin
            state_d = S_DONE;
          end else begin
            launch_d = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = r_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
      mod_q       <= WIDTH'(1);
      exp_q       <= WIDTH'(1);
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_MODULUS) begin
          mod_q <= cfg_data_i[WIDTH-1:0];
        end
        if (cfg_index_i == CFG_EXPONENT) begin
          exp_q <= cfg_data_i[WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    r_q   <= r_d;
    b_q   <= b_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DataW'(out_q);

endmodule

// ===== hdl/mexp_checker.sv =====
// port-level checker for the modular exponentiation block, with its bind
`include "modular_exponentiation_defines.svh"

module mexp_checker import mexp_pkg::*; #(
  parameter int unsigned WIDTH = DefaultWidth
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [DataW-1:0]   m_axis_tdata
);

  `MEXP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed under stall")
  `MEXP_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "new request taken while one is in work")
  `MEXP_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result appeared right after a request")
  `MEXP_ASSERT_NOW(a_result_width, m_axis_tvalid, (m_axis_tdata >> WIDTH) == '0, "result wider than the modulus width")

endmodule

bind modular_exponentiation mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (.*);

// ===== dv/modular_exponentiation_tb.sv =====
// testbench for modular_exponentiation: directed and random bases checked against a predictor
`timescale 1ns / 1ps

module modular_exponentiation_tb;
  import mexp_pkg::*;

  localparam int unsigned Width = DefaultWidth;
  localparam logic [DataW-1:0] ValueMask = {DataW{1'b1}} >> (DataW - Width);
  localparam logic [CfgIdxW-1:0] CfgIdxSpare0 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare1 = 2'd3;
  localparam int unsigned CycleLimit = 5_000_000;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [DataW-1:0]   s_axis_tdata;   // base_value
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [DataW-1:0]   m_axis_tdata;   // power_result
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DataW-1:0]   cfg_data_i;

  logic [DataW-1:0] modulus_cfg;
  logic [DataW-1:0] exponent_cfg;
  logic [DataW-1:0] expected_powers[$];
  logic [DataW-1:0] oldest_power;
  int               mismatch_count;
  int               sender_idle_pct;
  int               receiver_stall_pct;
  int               ready_hold_left;
  int unsigned      cycle_count;

  modular_exponentiation #(
    .WIDTH(Width)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("modular_exponentiation verification failed");
    $finish;
  end

  // modulus zero stands for 2^Width, products then just wrap
  function automatic logic [DataW-1:0] modmul(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                             logic [DataW-1:0] m);
    logic [2*DataW-1:0] prod;
    prod = {{DataW{1'b0}}, a} * {{DataW{1'b0}}, b};
    if (m == '0) begin
      return prod[DataW-1:0] & ValueMask;
    end
    prod = prod % {{DataW{1'b0}}, m};
    return prod[DataW-1:0];
  endfunction

  function automatic logic [DataW-1:0] predict_power(logic [DataW-1:0] base,
                                                     logic [DataW-1:0] modulus,
                                                     logic [DataW-1:0] exponent);
    logic [DataW-1:0] m;
    logic [DataW-1:0] e;
    logic [DataW-1:0] sq;
    logic [DataW-1:0] acc;
    m = modulus & ValueMask;
    e = exponent & ValueMask;
    sq = base & ValueMask;
    acc = 1;
    if (m != '0) begin
      sq = sq % m;
    end
    while (e != '0) begin
      if (e[0]) begin
        acc = modmul(acc, sq, m);
      end
      sq = modmul(sq, sq, m);
      e = e >> 1;
    end
    return acc & ValueMask;
  endfunction

  function automatic logic [DataW-1:0] pick_modulus();
    unique case ($urandom_range(9))
      0: return '0;
      1: return 1;
      2: return '1;
      3: return 64'd1 << $urandom_range(63);
      4: return $urandom_range(2, 255);
      5: return {32'h0, $urandom};
      6: return {$urandom, $urandom} | 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly short exponents, a full-length one now and then
  function automatic logic [DataW-1:0] pick_exponent();
    unique case ($urandom_range(11))
      0: return '0;
      1: return {$urandom, $urandom};
      2: return 1;
      default: return $urandom_range(2, 4095);
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_base(logic [DataW-1:0] m);
    unique case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return m - 1;
      3: return m;
      4: return m + $urandom_range(1, 3);
      5: return $urandom_range(255);
      6: return {32'h0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_powers.size() == 0) begin
        $display("%0t: unexpected power_result expected none actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        oldest_power = expected_powers.pop_front();
        if (m_axis_tdata !== oldest_power) begin
          $display("%0t: power_result mismatch expected %h actual %h",
                   $time, oldest_power, m_axis_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // result side ready, with an optional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (ready_hold_left > 0) begin
        ready_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    unique case (idx)
      CFG_MODULUS:  modulus_cfg = value;
      CFG_EXPONENT: exponent_cfg = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_base(input logic [DataW-1:0] base);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= base;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_powers.push_back(predict_power(base, modulus_cfg, exponent_cfg));
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (expected_powers.size() != 0);
  endtask

  task automatic test_reset_state();
    send_base('0);
    send_base('1);
    wait_for_results();
  endtask

  task automatic test_special_exponents();
    write_register(CFG_MODULUS, '1);
    write_register(CFG_EXPONENT, '0);
    send_base('1);
    send_base('0);
    wait_for_results();
    write_register(CFG_MODULUS, 1);
    send_base(5);
    wait_for_results();
  endtask

  task automatic test_modulus_extremes();
    write_register(CFG_MODULUS, '0);
    write_register(CFG_EXPONENT, 3);
    send_base('1);
    send_base(64'h0000_0001_0000_0001);
    send_base('0);
    wait_for_results();
    write_register(CFG_MODULUS, '1);
    write_register(CFG_EXPONENT, '1);
    send_base(64'hFFFF_FFFF_FFFF_FFFE);
    send_base(2);
    wait_for_results();
    write_register(CFG_MODULUS, 64'h8000_0000_0000_0000);
    write_register(CFG_EXPONENT, 2);
    send_base(64'h8000_0000_0000_0003);
    wait_for_results();
    write_register(CFG_MODULUS, 13);
    write_register(CFG_EXPONENT, 12);
    send_base(0);
    send_base(1);
    send_base(12);
    wait_for_results();
    write_register(CFG_MODULUS, 1000003);
    write_register(CFG_EXPONENT, 65537);
    send_base(1000003);
    send_base(1000004);
    send_base('1);
    wait_for_results();
  endtask

  task automatic test_ignored_index();
    write_register(CfgIdxSpare0, '0);
    write_register(CfgIdxSpare1, '0);
    send_base(7);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int sent;
    int batch;
    logic [DataW-1:0] m;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      m = pick_modulus();
      write_register(CFG_MODULUS, m);
      write_register(CFG_EXPONENT, pick_exponent());
      batch = $urandom_range(3, 8);
      if (batch > count - sent) begin
        batch = count - sent;
      end
      repeat (batch) begin
        send_base(pick_base(m));
        sent++;
      end
      wait_for_results();
    end
  endtask

  // output held off long enough that the block fills up and stalls its input
  task automatic test_backpressure();
    logic [DataW-1:0] m;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    m = {32'h0, $urandom} | 64'd1;
    write_register(CFG_MODULUS, m);
    write_register(CFG_EXPONENT, 5);
    ready_hold_left = 4000;
    repeat (6) send_base(pick_base(m));
    wait_for_results();
    repeat (2) send_base(pick_base(m));
    wait_for_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MODULUS;
    cfg_data_i = '0;
    modulus_cfg = 1;
    exponent_cfg = 1;
    mismatch_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    ready_hold_left = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_special_exponents();
    test_modulus_extremes();
    test_ignored_index();
    test_random_traffic(0, 0, 20);
    test_random_traffic(68, 0, 18);
    test_random_traffic(0, 68, 18);
    test_random_traffic(16, 16, 14);
    test_backpressure();

    wait_for_results();
    repeat (200) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("modular_exponentiation verification clean");
    end else begin
      $display("modular_exponentiation verification failed");
    end
    $finish;
  end

endmodule
